/* design/ptwe_pkg.sv */
`timescale 1ns / 1ps
package ptwe_pkg;
  localparam int CounterBits = 16;
  localparam int PosBits = 40;
  localparam int HeadBits = 23;
  localparam int WbBits = 28;
  localparam int ResBits = 24;
  localparam int DiffBits = 41;
  localparam int SqBits = 84;
  localparam int RootBits = 42;
  localparam int TravBits = 44;
  localparam logic signed [24:0] PiQ = 25'sd3294199;
  localparam logic signed [24:0] TwoPiQ = 25'sd6588398;
  localparam logic [WbBits-1:0] WheelBaseReset = 28'd4362076;
  localparam logic [ResBits-1:0] ResolutionReset = 24'd168;
  localparam logic RegWheelBase = 1'b0;
  localparam logic RegResolution = 1'b1;

  typedef struct packed {
    logic [DiffBits-1:0] dx;
    logic [DiffBits-1:0] dy;
    logic signed [24:0] dth;
    logic back;
  } work_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_TERM, S_SUM, S_DIV_R, S_DIV_L, S_DONE
  } back_state_t;
endpackage

/* design/ptwe_front.sv */
`timescale 1ns / 1ps
module ptwe_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [ptwe_pkg::PosBits-1:0] pos_x,
  input  logic signed [ptwe_pkg::PosBits-1:0] pos_y,
  input  logic signed [ptwe_pkg::HeadBits-1:0] heading,
  input  logic moving_backward,
  output logic q_valid,
  input  logic q_take,
  output ptwe_pkg::work_t q_item
);
  logic signed [ptwe_pkg::PosBits-1:0] px, py;
  logic signed [23:0] ph;
  logic signed [ptwe_pkg::DiffBits-1:0] sdx, sdy;
  logic signed [24:0] d0, dw;
  ptwe_pkg::work_t item;
  logic [1:0] cnt;
  ptwe_pkg::work_t slot [2];
  logic wr_ptr, rd_ptr;
  logic acc;

  assign full = cnt[1];
  assign acc = push && !full;
  assign q_valid = cnt != 2'd0;
  assign q_item = slot[rd_ptr];

  // classify: form differences and wrap heading change once
  always_comb begin
    sdx = {px[ptwe_pkg::PosBits-1], px} - {pos_x[ptwe_pkg::PosBits-1], pos_x};
    sdy = {py[ptwe_pkg::PosBits-1], py} - {pos_y[ptwe_pkg::PosBits-1], pos_y};
    d0 = {ph[23], ph} - 25'(heading);
    priority if (d0 > ptwe_pkg::PiQ) dw = d0 - ptwe_pkg::TwoPiQ;
    else if (d0 < -ptwe_pkg::PiQ) dw = d0 + ptwe_pkg::TwoPiQ;
    else dw = d0;
    item.dx = sdx[ptwe_pkg::DiffBits-1] ? -sdx : sdx;
    item.dy = sdy[ptwe_pkg::DiffBits-1] ? -sdy : sdy;
    item.dth = dw;
    item.back = moving_backward;
  end

  // hold previous pose and advance the two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; ph <= '0;
      cnt <= '0; wr_ptr <= 1'b0; rd_ptr <= 1'b0;
    end else begin
      if (acc) begin
        px <= pos_x; py <= pos_y; ph <= 24'(heading);
        wr_ptr <= ~wr_ptr;
      end
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(acc) - 2'(q_take && q_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) slot[wr_ptr] <= item;
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("take from empty queue");
  assert property (@(posedge clk) disable iff (rst)
      (acc && !(q_take && q_valid)) |=> cnt == $past(cnt) + 2'd1)
    else $error("fill count lost a transfer");
endmodule

/* design/ptwe_back.sv */
`timescale 1ns / 1ps
module ptwe_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  ptwe_pkg::work_t q_item,
  input  logic [ptwe_pkg::WbBits-1:0] wheel_base,
  input  logic [ptwe_pkg::ResBits-1:0] resolution,
  output logic empty,
  input  logic pop,
  output logic signed [ptwe_pkg::CounterBits-1:0] left_count,
  output logic signed [ptwe_pkg::CounterBits-1:0] right_count
);
  localparam int CW = ptwe_pkg::CounterBits;
  localparam int TB = ptwe_pkg::TravBits;
  ptwe_pkg::back_state_t state, state_next;
  ptwe_pkg::work_t w;
  logic [ptwe_pkg::SqBits-1:0] sq, rem_sq;
  logic [ptwe_pkg::RootBits-1:0] root;
  logic [5:0] step;
  logic [49:0] tprod;
  logic signed [TB-1:0] term, tot_l;
  logic signed [24:0] rem_r, rem_l;
  logic [CW-1:0] tick_r, tick_l;
  logic [TB-1:0] dmag, dquo;
  logic [TB:0] dacc;
  logic dneg;
  logic [ptwe_pkg::ResBits-1:0] rdiv;
  logic out_full;
  logic signed [TB-1:0] trav;
  logic [TB:0] shifted, diffv;
  logic [TB-1:0] quo_fin;
  logic [TB:0] rem_fin;
  logic [ptwe_pkg::DiffBits-1:0] sq_op;
  logic [20:0] mul_a, mul_b;
  logic [41:0] pprod;
  logic [ptwe_pkg::SqBits-1:0] pp_shifted;

  assign rdiv = (resolution == '0) ? ptwe_pkg::ResBits'(1) : resolution;
  assign q_take = (state == ptwe_pkg::S_IDLE) && q_valid;
  assign empty = !out_full;
  assign trav = w.back ? -TB'(root) : TB'(root);
  assign term = w.dth[24] ? -TB'(tprod >> 21) : TB'(tprod >> 21);
  assign shifted = {dacc[TB-1:0], dmag[TB-1]};
  assign diffv = shifted - (TB+1)'(rdiv);
  assign quo_fin = {dquo[TB-2:0], !diffv[TB]};
  assign rem_fin = diffv[TB] ? shifted : diffv;

  // square in three partial products: low*low, high*low, high*high
  assign sq_op = (state == ptwe_pkg::S_SQX) ? w.dx : w.dy;
  assign mul_a = (step == 6'd2) ? sq_op[20:0] : {1'b0, sq_op[40:21]};
  assign mul_b = (step == 6'd0) ? {1'b0, sq_op[40:21]} : sq_op[20:0];
  assign pprod = mul_a * mul_b;

  always_comb begin
    priority if (step == 6'd2) pp_shifted = {42'd0, pprod};
    else if (step == 6'd1) pp_shifted = {20'd0, pprod, 22'd0};
    else pp_shifted = {pprod, 42'd0};
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ptwe_pkg::S_IDLE: if (q_valid) state_next = ptwe_pkg::S_SQX;
      ptwe_pkg::S_SQX: if (step == 6'd0) state_next = ptwe_pkg::S_SQY;
      ptwe_pkg::S_SQY: if (step == 6'd0) state_next = ptwe_pkg::S_ROOT;
      ptwe_pkg::S_ROOT: if (step == 6'd0) state_next = ptwe_pkg::S_TERM;
      ptwe_pkg::S_TERM: state_next = ptwe_pkg::S_SUM;
      ptwe_pkg::S_SUM: state_next = ptwe_pkg::S_DIV_R;
      ptwe_pkg::S_DIV_R: if (step == 6'd0) state_next = ptwe_pkg::S_DIV_L;
      ptwe_pkg::S_DIV_L: if (step == 6'd0) state_next = ptwe_pkg::S_DONE;
      ptwe_pkg::S_DONE: if (!out_full) state_next = ptwe_pkg::S_IDLE;
      default: state_next = ptwe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ptwe_pkg::S_IDLE;
    else state <= state_next;
  end

  // datapath: one root bit per cycle (digit-by-digit, no multiply), one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_r <= '0; rem_l <= '0; tick_r <= '0; tick_l <= '0; out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        ptwe_pkg::S_IDLE: if (q_valid) begin
          w <= q_item;
          sq <= '0;
          step <= 6'd2;
        end
        ptwe_pkg::S_SQX: begin
          sq <= sq + pp_shifted;
          if (step != 6'd0) step <= step - 6'd1;
          else step <= 6'd2;
        end
        ptwe_pkg::S_SQY: begin
          sq <= sq + pp_shifted;
          if (step != 6'd0) step <= step - 6'd1;
          else begin
            root <= '0; rem_sq <= '0; step <= 6'd41;
          end
        end
        ptwe_pkg::S_ROOT: begin
          // rem_sq holds root squared; keep the bit if the candidate square fits
          if ((rem_sq + ({root, 1'b0} << step) + (ptwe_pkg::SqBits'(1) << {step, 1'b0}))
              <= sq) begin
            rem_sq <= rem_sq + ({root, 1'b0} << step) + (ptwe_pkg::SqBits'(1) << {step, 1'b0});
            root <= root | (ptwe_pkg::RootBits'(1) << step);
          end
          if (step != 6'd0) step <= step - 6'd1;
        end
        ptwe_pkg::S_TERM: tprod <= 50'(wheel_base) *
            50'(w.dth[24] ? -w.dth : w.dth);
        ptwe_pkg::S_SUM: begin
          tot_l <= trav - term + TB'(rem_l);
          dneg <= (trav + term + TB'(rem_r)) < 0;
          dmag <= ((trav + term + TB'(rem_r)) < 0) ? -(trav + term + TB'(rem_r))
                                                   : (trav + term + TB'(rem_r));
          dacc <= '0; dquo <= '0; step <= 6'(TB-1);
        end
        ptwe_pkg::S_DIV_R, ptwe_pkg::S_DIV_L: begin
          if (step != 6'd0) begin
            if (!diffv[TB]) begin
              dacc <= diffv; dquo <= {dquo[TB-2:0], 1'b1};
            end else begin
              dacc <= shifted; dquo <= {dquo[TB-2:0], 1'b0};
            end
            dmag <= {dmag[TB-2:0], 1'b0};
            step <= step - 6'd1;
          end else if (state == ptwe_pkg::S_DIV_R) begin
            tick_r <= tick_r + CW'(dneg ? -quo_fin : quo_fin);
            rem_r <= 25'(dneg ? -rem_fin : rem_fin);
            dneg <= tot_l < 0;
            dmag <= (tot_l < 0) ? -tot_l : tot_l;
            dacc <= '0; dquo <= '0; step <= 6'(TB-1);
          end else begin
            tick_l <= tick_l + CW'(dneg ? -quo_fin : quo_fin);
            rem_l <= 25'(dneg ? -rem_fin : rem_fin);
          end
        end
        ptwe_pkg::S_DONE: if (!out_full) begin
          out_full <= 1'b1;
          left_count <= tick_l;
          right_count <= tick_r;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      q_take |-> state == ptwe_pkg::S_IDLE)
    else $error("take while busy");
  assert property (@(posedge clk) disable iff (rst)
      (state == ptwe_pkg::S_DONE && !out_full) |=> out_full)
    else $error("result not posted");
  assert property (@(posedge clk) disable iff (rst)
      (out_full && !pop) |=> $stable(left_count) && $stable(right_count))
    else $error("waiting result changed");
endmodule

/* design/pose_to_wheel_encoder_emulator_unit.sv */
`timescale 1ns / 1ps
// Differential-drive inverse odometry: each pose pushed in yields one pair of
// wrapping left/right tick counters. The back end works on one item at a time:
// it takes the item, forms the two squares (three narrow partial products
// each), the bit-per-cycle square root of the travel, the turn term and the
// wheel sums, two restoring divisions by the encoder resolution, and posts the
// result. The last step stalls while an earlier result has not been popped. A
// two-entry queue in front lets poses be pushed while the back end works.
// Configuration (index 0 wheel_base, 1 encoder_resolution) is to be written by
// the user when idle; the block itself does not enforce this.
module pose_to_wheel_encoder_emulator_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [39:0] pos_x,
  input  logic signed [39:0] pos_y,
  input  logic signed [22:0] heading,
  input  logic moving_backward,
  output logic empty,
  input  logic pop,
  output logic signed [15:0] left_count,
  output logic signed [15:0] right_count,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [27:0] cfg_data
);
  logic q_valid, q_take;
  ptwe_pkg::work_t q_item;
  logic [ptwe_pkg::WbBits-1:0] wheel_base;
  logic [ptwe_pkg::ResBits-1:0] resolution;

  assign cfg_ready = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base <= ptwe_pkg::WheelBaseReset;
      resolution <= ptwe_pkg::ResolutionReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ptwe_pkg::RegWheelBase: wheel_base <= cfg_data;
        ptwe_pkg::RegResolution: resolution <= cfg_data[ptwe_pkg::ResBits-1:0];
        default: ;
      endcase
    end
  end

  ptwe_front u_front (
    .clk, .rst, .push, .full, .pos_x, .pos_y, .heading, .moving_backward,
    .q_valid, .q_take, .q_item
  );

  ptwe_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .wheel_base, .resolution,
    .empty, .pop, .left_count, .right_count
  );
endmodule

/* verif/tb_pose_to_wheel_encoder_emulator_unit.sv */
`timescale 1ns / 1ps
module tb_pose_to_wheel_encoder_emulator_unit;

  localparam longint CycleLimit = 2000000;
  localparam int DrainCycles = 250;
  localparam longint PosMax = 64'sd549755813887;
  localparam longint PosMin = -64'sd549755813888;

  typedef struct {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [22:0] h;
    logic back;
  } pose_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } counts_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [39:0] pos_x = '0;
  logic signed [39:0] pos_y = '0;
  logic signed [22:0] heading = '0;
  logic moving_backward = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = ptwe_pkg::RegWheelBase;
  logic [27:0] cfg_data = '0;

  pose_t pending_poses[$];
  counts_t expected_counts[$];
  pose_t on_port;
  int errors = 0;
  bit calm = 0;
  int hold_request = 0;
  longint cycles = 0;

  // Odometry state mirrored by the testbench
  longint wheel_base_q;
  longint resolution_q;
  longint last_x, last_y, last_h;
  longint rem_left, rem_right;
  logic [15:0] ticks_left, ticks_right;

  // Generator's idea of the present pose
  longint gen_x, gen_y, gen_h;

  pose_to_wheel_encoder_emulator_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .moving_backward(moving_backward), .empty(empty), .pop(pop),
    .left_count(left_count), .right_count(right_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // floor(sqrt(a^2 + b^2)), one root bit at a time
  function automatic longint travel_floor(longint a, longint b);
    logic [83:0] sq, c, root;
    sq = 84'(a) * 84'(a) + 84'(b) * 84'(b);
    root = '0;
    for (int bit_i = 41; bit_i >= 0; bit_i--) begin
      c = root | (84'd1 << bit_i);
      if (c * c <= sq) root = c;
    end
    return longint'(root);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Advance the mirrored state by one pose and queue the resulting counters
  task automatic predict_counts(pose_t p);
    longint travel, dth, turn, divisor, total, ticks;
    counts_t c;
    travel = travel_floor(abs_l(last_x - longint'(p.x)), abs_l(last_y - longint'(p.y)));
    if (p.back) travel = -travel;
    dth = last_h - longint'(p.h);
    if (dth > longint'(ptwe_pkg::PiQ)) dth -= longint'(ptwe_pkg::TwoPiQ);
    else if (dth < -longint'(ptwe_pkg::PiQ)) dth += longint'(ptwe_pkg::TwoPiQ);
    turn = (wheel_base_q * abs_l(dth)) >>> 21;
    if (dth < 0) turn = -turn;
    last_x = p.x;
    last_y = p.y;
    last_h = p.h;
    divisor = resolution_q == 0 ? 1 : resolution_q;
    total = travel + turn + rem_right;
    ticks = total / divisor;
    rem_right = total - ticks * divisor;
    ticks_right = ticks_right + 16'(ticks);
    total = travel - turn + rem_left;
    ticks = total / divisor;
    rem_left = total - ticks * divisor;
    ticks_left = ticks_left + 16'(ticks);
    c.left = ticks_left;
    c.right = ticks_right;
    expected_counts.push_back(c);
  endtask

  // Feed poses; hold an offered pose until the transfer happens
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_counts(on_port);
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          push <= 1'b0;
        end else if (pending_poses.size() > 0) begin
          on_port = pending_poses.pop_front();
          pos_x <= on_port.x;
          pos_y <= on_port.y;
          heading <= on_port.h;
          moving_backward <= on_port.back;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Take results and compare against the oldest expectation
  int take_gap = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    counts_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result left=%0d right=%0d", $time, left_count,
                   right_count);
          errors++;
        end else begin
          e = expected_counts.pop_front();
          if (left_count !== e.left) begin
            $display("%0t: left_count expected %0d actual %0d", $time, e.left, left_count);
            errors++;
          end
          if (right_count !== e.right) begin
            $display("%0t: right_count expected %0d actual %0d", $time, e.right,
                     right_count);
            errors++;
          end
        end
      end
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        take_gap = 600;
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        take_gap = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL pose_to_wheel_encoder_emulator_unit");
      $finish;
    end
  end

  task automatic add_pose(longint x, longint y, longint h, bit back);
    pose_t p;
    p.x = 40'(x);
    p.y = 40'(y);
    p.h = 23'(h);
    p.back = back;
    pending_poses.push_back(p);
    gen_x = p.x;
    gen_y = p.y;
    gen_h = p.h;
  endtask

  function automatic longint rand40();
    return longint'($signed(40'({$urandom, $urandom})));
  endfunction

  // Mostly smooth trajectories, some jumps to arbitrary and extreme poses
  task automatic add_random(int n);
    int kind;
    longint h;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        h = gen_h + $urandom_range(0, 400000) - 200000;
        if (h > longint'(ptwe_pkg::PiQ)) h -= longint'(ptwe_pkg::TwoPiQ);
        if (h < -longint'(ptwe_pkg::PiQ)) h += longint'(ptwe_pkg::TwoPiQ);
        add_pose(gen_x + $urandom_range(0, 4000000) - 2000000,
                 gen_y + $urandom_range(0, 4000000) - 2000000, h,
                 $urandom_range(0, 3) == 0);
      end else if (kind < 92) begin
        add_pose(rand40(), rand40(), longint'($signed(23'($urandom))), $urandom_range(0, 1));
      end else begin
        add_pose($urandom_range(0, 1) ? PosMax : PosMin,
                 $urandom_range(0, 1) ? PosMax : PosMin,
                 $urandom_range(0, 1) ? 4194303 : -4194304, $urandom_range(0, 1));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_poses.size() != 0 || push || expected_counts.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [27:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ptwe_pkg::RegWheelBase) wheel_base_q = val;
    else resolution_q = val[23:0];
  endtask

  initial begin
    wheel_base_q = ptwe_pkg::WheelBaseReset;
    resolution_q = ptwe_pkg::ResolutionReset;
    last_x = 0; last_y = 0; last_h = 0;
    rem_left = 0; rem_right = 0;
    ticks_left = '0; ticks_right = '0;
    gen_x = 0; gen_y = 0; gen_h = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: first move from the origin, field extremes, wrap of heading
    add_pose(0, 0, 0, 0);
    add_pose(1000000, 0, 0, 0);
    add_pose(1000000, 1000000, 3294199, 0);
    add_pose(0, 0, -3294199, 1);
    add_pose(PosMax, PosMax, 0, 0);
    add_pose(PosMin, PosMin, 4194303, 0);
    add_pose(PosMin, PosMin, -4194304, 1);
    add_pose(PosMax, PosMin, 3294199, 1);
    add_pose(0, 0, -3294199, 0);
    add_pose(0, 0, 3294199, 0);
    add_pose(-1, -1, -1, 1);
    add_pose(12345, -67890, 100, 1);
    add_pose(12345, -67890, -100, 0);
    add_pose(0, 0, 0, 0);
    wait_idle();

    add_random(180);
    wait_idle();

    // Widest wheel base, finest resolution: counters wrap quickly
    write_reg(ptwe_pkg::RegWheelBase, 28'hFFFFFFF);
    write_reg(ptwe_pkg::RegResolution, 28'd1);
    add_pose(PosMax, PosMax, 4194303, 0);
    add_pose(PosMin, PosMin, -4194304, 0);
    hold_request = 1;
    add_random(180);
    wait_idle();

    // Narrowest wheel base, coarsest resolution
    write_reg(ptwe_pkg::RegWheelBase, 28'd1);
    write_reg(ptwe_pkg::RegResolution, 28'hFFFFFF);
    add_random(170);
    wait_idle();

    // Zero resolution behaves as one
    write_reg(ptwe_pkg::RegResolution, 28'd0);
    write_reg(ptwe_pkg::RegWheelBase, 28'($urandom));
    add_random(170);
    wait_idle();

    write_reg(ptwe_pkg::RegWheelBase, 28'($urandom_range(1, 268435455)));
    write_reg(ptwe_pkg::RegResolution, 28'($urandom_range(1, 5000)));
    calm = 1;
    add_random(230);
    wait_idle();

    if (errors == 0) begin
      $display("PASS pose_to_wheel_encoder_emulator_unit");
    end else begin
      $display("FAIL pose_to_wheel_encoder_emulator_unit");
    end
    $finish;
  end
endmodule

/* pose_to_wheel_encoder_emulator_unit.f */
design/ptwe_pkg.sv
design/ptwe_front.sv
design/ptwe_back.sv
design/pose_to_wheel_encoder_emulator_unit.sv
verif/tb_pose_to_wheel_encoder_emulator_unit.sv
